// ===== design/arnp_pkg.sv =====
// ----------------------------------------------------------------------------
// arnp_pkg
// Shared widths, codes and types for the ASCII radix number parser.
// ----------------------------------------------------------------------------
package arnp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 8;

    // classified-character queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // radix / base codes
    localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_WIDTH-1:0] RADIX_ONE   = 6'd1;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_HEX    = 6'd16;

    // digit code for a character that is no digit at all (above any base)
    localparam logic [RADIX_WIDTH-1:0] NO_DIGIT    = 6'd63;

    // one classified character
    typedef struct packed {
        logic                   first;
        logic                   space;
        logic                   zero;
        logic                   xchar;
        logic [RADIX_WIDTH-1:0] digit;
    } t_char_cls;

endpackage

// ===== design/arnp_front.sv =====
// ----------------------------------------------------------------------------
// arnp_front
// Input handshake and character classification feeding the queue.
// ----------------------------------------------------------------------------
module arnp_front
    import arnp_pkg::*;
(
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CHAR_WIDTH-1:0] i_ch,
    input  logic                  i_first,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_char_cls             o_entry
);

    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CASE_BIT = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] ALPHA_OFS = 8'd10;

    logic [CHAR_WIDTH-1:0] w_low;
    logic [CHAR_WIDTH-1:0] w_dec;
    logic [CHAR_WIDTH-1:0] w_alp;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign w_low = i_ch | CASE_BIT;
    assign w_dec = i_ch - CH_0;
    assign w_alp = w_low - CH_LA + ALPHA_OFS;

    always_comb begin
        o_entry.first = i_first;
        o_entry.space = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_entry.zero  = (i_ch == CH_0);
        o_entry.xchar = (i_ch == CH_LX) || (i_ch == CH_UX);
        if ((i_ch >= CH_0) && (i_ch <= CH_9)) begin
            o_entry.digit = w_dec[RADIX_WIDTH-1:0];
        end else if ((w_low >= CH_LA) && (w_low <= CH_LZ)) begin
            o_entry.digit = w_alp[RADIX_WIDTH-1:0];
        end else begin
            o_entry.digit = NO_DIGIT;
        end
    end

endmodule

// ===== design/arnp_queue.sv =====
// ----------------------------------------------------------------------------
// arnp_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module arnp_queue
    import arnp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_char_cls i_entry,
    output logic      o_full,
    output logic      o_valid,
    output t_char_cls o_entry,
    input  logic      i_pop
);

    localparam logic [QAW-1:0] LAST_IDX = QAW'(QDEPTH - 1);
    localparam logic [QAW:0]   DEPTH_CNT = (QAW + 1)'(QDEPTH);

    t_char_cls          r_mem [QDEPTH];
    logic [QAW-1:0]     r_wr;
    logic [QAW-1:0]     r_rd;
    logic [QAW:0]       r_count;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_entry;
                r_wr        <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/arnp_back.sv =====
// ----------------------------------------------------------------------------
// arnp_back
// Parse sequencer: prefix handling, digit fold with overflow, result register.
// ----------------------------------------------------------------------------
module arnp_back
    import arnp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [RADIX_WIDTH-1:0] i_radix,
    input  logic                   i_q_valid,
    input  t_char_cls              i_entry,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [COUNT_WIDTH-1:0] o_end_offset,
    output logic                   o_overflow
);

    localparam int PW = VALUE_WIDTH + RADIX_WIDTH;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    function automatic logic [COUNT_WIDTH-1:0] f_sat_add(
        input logic [COUNT_WIDTH-1:0] c,
        input logic [1:0]             n
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, c} + (COUNT_WIDTH + 1)'(n);
        return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    t_phase                 r_phase, n_phase, w_phase;
    logic [RADIX_WIDTH-1:0] r_base, n_base, w_base, f_base, w_sel;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc, w_acc, f_acc;
    logic [COUNT_WIDTH-1:0] r_count, n_count, w_count;
    logic                   f_do;
    logic [PW-1:0]          w_mac;
    logic                   w_emit;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [COUNT_WIDTH-1:0] w_off;
    logic                   w_ovf;
    logic                   w_bad;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [COUNT_WIDTH-1:0] r_end;
    logic                   r_ovf;

    assign o_pop        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_end_offset = r_end;
    assign o_overflow   = r_ovf;

    assign w_bad = (i_radix == RADIX_ONE) || (i_radix > RADIX_MAX);
    assign w_sel = (i_radix == RADIX_AUTO) ? BASE_DEC : i_radix;

    always_comb begin
        // first flag restarts the string before the character is handled
        w_phase = i_entry.first ? PH_SPACE : r_phase;
        w_base  = i_entry.first ? '0 : r_base;
        w_acc   = i_entry.first ? '0 : r_acc;
        w_count = i_entry.first ? '0 : r_count;

        n_phase = w_phase;
        n_base  = w_base;
        n_acc   = w_acc;
        n_count = w_count;
        f_do    = 1'b0;
        f_acc   = w_acc;
        f_base  = w_base;
        w_emit  = 1'b0;
        w_val   = '0;
        w_off   = '0;
        w_ovf   = 1'b0;

        case (w_phase)
            PH_SPACE: begin
                if (i_entry.space) begin
                    n_count = f_sat_add(w_count, 2'd1);
                end else if (w_bad) begin
                    w_emit = 1'b1;
                end else if (i_entry.zero &&
                             ((i_radix == RADIX_AUTO) || (i_radix == BASE_HEX))) begin
                    n_base  = (i_radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
                    n_acc   = '0;
                    n_count = f_sat_add(w_count, 2'd1);
                    n_phase = PH_ZERO;
                end else begin
                    n_base = w_sel;
                    n_acc  = '0;
                    if (i_entry.digit >= w_sel) begin
                        w_emit = 1'b1;
                    end else begin
                        n_phase = PH_DIGITS;
                        f_do    = 1'b1;
                        f_acc   = '0;
                        f_base  = w_sel;
                    end
                end
            end
            PH_ZERO: begin
                if (i_entry.xchar) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_DIGITS;
                    f_do    = 1'b1;
                end
            end
            PH_PREFIX: begin
                // "0x" with no hex digit: offset stays just after the '0'
                if (i_entry.digit >= BASE_HEX) begin
                    w_emit = 1'b1;
                    w_off  = w_count;
                end else begin
                    n_acc   = VALUE_WIDTH'(i_entry.digit);
                    n_count = f_sat_add(w_count, 2'd2);
                    n_phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                f_do = 1'b1;
            end
            default: begin
            end
        endcase

        // fold: acc*base+digit, overflow when it leaves VALUE_WIDTH bits
        w_mac = PW'(f_acc) * PW'(f_base) + PW'(i_entry.digit);
        if (f_do) begin
            if (i_entry.digit >= f_base) begin
                w_emit = 1'b1;
                w_val  = f_acc;
                w_off  = w_count;
            end else if (|w_mac[PW-1:VALUE_WIDTH]) begin
                w_emit = 1'b1;
                w_val  = '1;
                w_off  = w_count;
                w_ovf  = 1'b1;
            end else begin
                n_acc   = w_mac[VALUE_WIDTH-1:0];
                n_count = f_sat_add(w_count, 2'd1);
            end
        end
        if (w_emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_base      <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_count <= n_count;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
                r_value     <= w_val;
                r_end       <= w_off;
                r_ovf       <= w_ovf;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/ascii_radix_number_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_radix_number_parser
// Unsigned string-to-integer conversion, one character per cycle if unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one character word per beat,
//   i_first marks the first character of a string, a NUL ends it. Leading
//   whitespace is skipped, radix 0 picks hex/octal/decimal from the prefix,
//   radix 16 also takes "0x".
//   Output channel (o_out_valid / i_out_stall): one result word per string:
//   value (all ones on overflow), end offset (saturating), overflow flag.
//   Config channel (i_cfg_valid / o_cfg_ready): radix, always ready; write
//   it only while no string is in flight.
//   Throughput: one character per cycle while no stall is raised. The
//   rate is set by the back-end fold, one 32x6 multiply-add with its
//   overflow check per cycle. Result path: the stopping character is
//   written into the queue, then folded into the output register, which
//   holds the result word.
//   A stalled receiver holds the result and the back end stops popping; the
//   two-entry queue takes up to two more words, then o_in_stall rises.
//   Reset: radix returns to 10, the parser goes idle, queue and output empty.
// ----------------------------------------------------------------------------
module ascii_radix_number_parser
    import arnp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIX_WIDTH-1:0] i_cfg_data,
    // character input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CHAR_WIDTH-1:0]  i_ch,
    input  logic                   i_first,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [COUNT_WIDTH-1:0] o_end_offset,
    output logic                   o_overflow
);

    logic [RADIX_WIDTH-1:0] r_radix;
    logic                   w_push, w_full, w_q_valid, w_pop;
    t_char_cls              w_in_entry, w_q_entry;

    // radix register, sampled by the back end at the first non-space char
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    // front: handshake plus classification (space, '0', 'x', digit value)
    arnp_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_ch       (i_ch),
        .i_first    (i_first),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_entry    (w_in_entry)
    );

    // decouples front from the back end's output stalls
    arnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    // back: phase sequencer, fold and result register
    arnp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radix      (r_radix),
        .i_q_valid    (w_q_valid),
        .i_entry      (w_q_entry),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_end_offset (o_end_offset),
        .o_overflow   (o_overflow)
    );

    // overflow always reports the saturated value
    a_ovf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_value == '1))
        else $error("overflow result without all-ones value");

    // an overflow needs at least one digit folded before it
    a_ovf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_end_offset != '0))
        else $error("overflow result with zero end offset");

    // reset empties the output register and the queue
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output or queue not cleared by reset");

endmodule

// ===== tb/arnp_parse_checker.sv =====
// ----------------------------------------------------------------------------
// arnp_parse_checker
// Watches the config, character and result channels of the ASCII radix number
// parser. It keeps its own parser state and compares every result word
// with the oldest predicted number.
// ----------------------------------------------------------------------------
module arnp_parse_checker
    import arnp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [RADIX_WIDTH-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [CHAR_WIDTH-1:0]  i_ch,
    input  logic                   i_first,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [COUNT_WIDTH-1:0] i_end_offset,
    input  logic                   i_overflow,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_chars,
    output int                     o_numbers,
    output int                     o_overflows,
    output int                     o_radix_writes
);

    localparam int MAX_LOGGED = 40;
    localparam logic [VALUE_WIDTH-1:0] VALUE_ALL_ONES = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ALL_ONES = '1;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_SPACE,
        PARSE_ZERO,
        PARSE_PREFIX,
        PARSE_DIGITS
    } t_parse_phase;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_WIDTH-1:0] end_offset;
        logic                   overflow;
    } t_number;

    logic [RADIX_WIDTH-1:0] cfg_radix;
    t_parse_phase           phase;
    logic [RADIX_WIDTH-1:0] base_now;
    logic [VALUE_WIDTH-1:0] acc;
    logic [COUNT_WIDTH-1:0] consumed;
    t_number                due_numbers[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_chars        = 0;
        o_numbers      = 0;
        o_overflows    = 0;
        o_radix_writes = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_LOGGED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic [RADIX_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] low;
        low = c | 8'h20;
        if (c >= "0" && c <= "9") begin
            return RADIX_WIDTH'(c - "0");
        end
        if (low >= "a" && low <= "z") begin
            return RADIX_WIDTH'(low - "a" + 8'd10);
        end
        return NO_DIGIT;
    endfunction

    function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic reset_parser();
        cfg_radix = RADIX_RESET;
        phase     = PARSE_IDLE;
        base_now  = '0;
        acc       = '0;
        consumed  = '0;
    endtask

    // saturating character count
    task automatic add_consumed(input int n);
        if (int'(COUNT_ALL_ONES) - int'(consumed) < n) begin
            consumed = COUNT_ALL_ONES;
        end else begin
            consumed = consumed + COUNT_WIDTH'(n);
        end
    endtask

    task automatic finish_number(input logic [VALUE_WIDTH-1:0] v,
                                 input logic [COUNT_WIDTH-1:0] off,
                                 input logic ovf);
        t_number n;
        n.value      = v;
        n.end_offset = off;
        n.overflow   = ovf;
        due_numbers.push_back(n);
        phase = PARSE_IDLE;
    endtask

    task automatic fold_digit(input logic [CHAR_WIDTH-1:0] c);
        logic [RADIX_WIDTH-1:0] d;
        longint unsigned        acc_wide;
        longint unsigned        limit;
        d        = digit_value(c);
        acc_wide = acc;
        if (d >= base_now) begin
            finish_number(acc, consumed, 1'b0);
        end else begin
            // exactly the maximum is still legal
            limit = (longint'(VALUE_ALL_ONES) - d) / base_now;
            if (acc_wide > limit) begin
                finish_number(VALUE_ALL_ONES, consumed, 1'b1);
            end else begin
                acc = VALUE_WIDTH'(acc_wide * base_now + d);
                add_consumed(1);
            end
        end
    endtask

    task automatic parse_char(input logic [CHAR_WIDTH-1:0] c, input logic f);
        if (f) begin
            phase    = PARSE_SPACE;
            base_now = '0;
            acc      = '0;
            consumed = '0;
        end
        case (phase)
            PARSE_SPACE: begin
                if (is_blank(c)) begin
                    add_consumed(1);
                end else if (cfg_radix == RADIX_ONE || cfg_radix > RADIX_MAX) begin
                    finish_number('0, '0, 1'b0);
                end else begin
                    acc = '0;
                    if (c == "0" && (cfg_radix == RADIX_AUTO || cfg_radix == BASE_HEX)) begin
                        base_now = (cfg_radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
                        add_consumed(1);
                        phase = PARSE_ZERO;
                    end else begin
                        base_now = (cfg_radix == RADIX_AUTO) ? BASE_DEC : cfg_radix;
                        if (digit_value(c) >= base_now) begin
                            finish_number('0, '0, 1'b0);
                        end else begin
                            phase = PARSE_DIGITS;
                            fold_digit(c);
                        end
                    end
                end
            end
            PARSE_ZERO: begin
                if (c == "x" || c == "X") begin
                    base_now = BASE_HEX;
                    phase    = PARSE_PREFIX;
                end else begin
                    phase = PARSE_DIGITS;
                    fold_digit(c);
                end
            end
            PARSE_PREFIX: begin
                // "0x" with no hex digit after it: offset stays just past the 0
                if (digit_value(c) >= BASE_HEX) begin
                    finish_number('0, consumed, 1'b0);
                end else begin
                    acc = VALUE_WIDTH'(digit_value(c));
                    add_consumed(2);
                    phase = PARSE_DIGITS;
                end
            end
            PARSE_DIGITS: fold_digit(c);
            default: ;
        endcase
    endtask

    task automatic check_number();
        t_number want;
        if (due_numbers.size() == 0) begin
            report_mismatch($sformatf("result word %h/%0d/%b with nothing expected",
                                      i_value, i_end_offset, i_overflow));
        end else begin
            want = due_numbers.pop_front();
            if (i_value != want.value) begin
                report_mismatch($sformatf("value %h, expected %h", i_value, want.value));
            end
            if (i_end_offset != want.end_offset) begin
                report_mismatch($sformatf("end_offset %0d, expected %0d",
                                          i_end_offset, want.end_offset));
            end
            if (i_overflow != want.overflow) begin
                report_mismatch($sformatf("overflow %b, expected %b",
                                          i_overflow, want.overflow));
            end
        end
        o_numbers++;
        if (i_overflow) begin
            o_overflows++;
        end
    endtask

    // a result word never shows at the edge that accepts its character, so the
    // output side is handled first within an edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            due_numbers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_number();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cfg_radix = i_cfg_data;
                o_radix_writes++;
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_ch, i_first);
                o_chars++;
            end
        end
        o_pending = due_numbers.size();
    end

endmodule

// ===== tb/tb_ascii_radix_number_parser.sv =====
// ----------------------------------------------------------------------------
// tb_ascii_radix_number_parser
// Stimulus and verdict for the ASCII radix number parser. A directed pass
// covers the corner cases, then random strings run under three idle
// profiles and many radix settings; a separate checker predicts each number.
// ----------------------------------------------------------------------------
module tb_ascii_radix_number_parser;
    import arnp_pkg::*;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 6;     // margin behind the queue and output register
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
    localparam int PHASE_CHARS    = 700;
    localparam int RETUNE_EVERY   = 10;    // strings between radix changes

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN_BASE = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_OVER     = RADIX_MAX + 6'd1;
    localparam logic [RADIX_WIDTH-1:0] RADIX_TOP      = '1;

    // DUT inputs, all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [RADIX_WIDTH-1:0] i_cfg_data  = RADIX_RESET;
    logic                   i_in_valid  = 1'b0;
    logic [CHAR_WIDTH-1:0]  i_ch        = '0;
    logic                   i_first     = 1'b0;
    logic                   i_out_stall = 1'b0;

    wire                    o_cfg_ready;
    wire                    o_in_stall;
    wire                    o_out_valid;
    wire [VALUE_WIDTH-1:0]  o_value;
    wire [COUNT_WIDTH-1:0]  o_end_offset;
    wire                    o_overflow;

    int fail_count;
    int pending;
    int chars_seen;
    int numbers_seen;
    int overflows_seen;
    int radix_writes;

    // stimulus knobs; the receiver process reads recv_idle_pct and hold_reqs
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;   // bumped by stimulus to ask for a hold-off
    int hold_seen     = 0;
    int hold_left     = 0;
    int chars_sent    = 0;
    int idle_cycles   = 0;

    logic [RADIX_WIDTH-1:0] cur_radix = RADIX_RESET;
    logic [CHAR_WIDTH:0]    word_q[$];   // {first, ch} per character word

    always #1 i_clk = ~i_clk;

    ascii_radix_number_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_first      (i_first),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_end_offset (o_end_offset),
        .o_overflow   (o_overflow)
    );

    arnp_parse_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_ch           (i_ch),
        .i_first        (i_first),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_value        (o_value),
        .i_end_offset   (o_end_offset),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_chars        (chars_seen),
        .o_numbers      (numbers_seen),
        .o_overflows    (overflows_seen),
        .o_radix_writes (radix_writes)
    );

    // Receiver: random stall, or a counted hold-off when stimulus asks.
    // One assignment to the stall per falling edge.
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: any word moving on any channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // One character word. Entered and left just after a falling edge, so the
    // valid keeps a single assignment per step when words go back to back.
    task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_first    <= f;
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_words();
        foreach (word_q[k]) begin
            send_char(word_q[k][CHAR_WIDTH-1:0], word_q[k][CHAR_WIDTH]);
        end
        word_q.delete();
    endtask

    // a literal string, first flag on its first character, no terminator
    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            word_q.push_back({1'b0, 8'(s[k])});
        end
        word_q[0][CHAR_WIDTH] = 1'b1;
        send_words();
    endtask

    // Sender pause: every expected number is in, then the tail latency.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_WIDTH-1:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_radix = r;
    endtask

    // A first-flagged NUL always ends in a result and leaves the parser idle,
    // so an open string never straddles a radix change.
    task automatic retune(input logic [RADIX_WIDTH-1:0] r);
        send_char(8'd0, 1'b1);
        drain();
        write_radix(r);
    endtask

    // fixed sweep of the extremes first, then mostly legal random bases
    function automatic logic [RADIX_WIDTH-1:0] pick_radix(input int n);
        int sel;
        sel = (n < 10) ? n : $urandom_range(0, 14);
        case (sel)
            0, 9:    return RADIX_AUTO;
            1:       return RADIX_MIN_BASE;
            2:       return RADIX_MAX;
            3:       return BASE_HEX;
            4:       return BASE_DEC;
            5:       return BASE_OCT;
            6:       return RADIX_ONE;
            7:       return RADIX_OVER;
            8:       return RADIX_TOP;
            default: return RADIX_WIDTH'($urandom_range(int'(RADIX_MIN_BASE), int'(RADIX_MAX)));
        endcase
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'd32 : CHAR_WIDTH'(r);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input int d);
        if (d < 10) begin
            return CHAR_WIDTH'("0" + d);
        end
        return ($urandom_range(0, 1) ? "A" : "a") + CHAR_WIDTH'(d - 10);
    endfunction

    // Well-formed string for the current radix: optional blanks, optional
    // prefix, digits (sometimes right at the 32-bit boundary), mostly a terminator.
    task automatic build_number();
        int                    base;
        int                    mode;
        int                    term;
        longint unsigned       v;
        logic [CHAR_WIDTH-1:0] digits[$];
        repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0) begin
            word_q.push_back({1'b0, blank_char()});
        end
        if (cur_radix == RADIX_AUTO) begin
            case ($urandom_range(0, 3))
                0: begin
                    word_q.push_back({1'b0, 8'("0")});
                    word_q.push_back({1'b0, $urandom_range(0, 1) ? 8'("x") : 8'("X")});
                    base = 16;
                end
                1: begin
                    word_q.push_back({1'b0, 8'("0")});
                    base = 8;
                end
                default: base = 10;
            endcase
        end else if (cur_radix == BASE_HEX) begin
            base = 16;
            if ($urandom_range(0, 1)) begin
                word_q.push_back({1'b0, 8'("0")});
                word_q.push_back({1'b0, $urandom_range(0, 1) ? 8'("x") : 8'("X")});
            end
        end else if (cur_radix == RADIX_ONE || cur_radix > RADIX_MAX) begin
            base = 10;   // rejected by the block anyway
        end else begin
            base = int'(cur_radix);
        end
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            // 2^32-3 .. 2^32+3: exact maximum and the first overflow
            v = 64'h1_0000_0000 + 64'($urandom_range(0, 6)) - 64'd3;
            do begin
                digits.push_front(digit_char(int'(v % base)));
                v = v / base;
            end while (v != 0);
        end else begin
            repeat ((mode == 1) ? $urandom_range(0, 36) : $urandom_range(0, 7)) begin
                digits.push_back(digit_char($urandom_range(0, base - 1)));
            end
        end
        foreach (digits[k]) begin
            word_q.push_back({1'b0, digits[k]});
        end
        term = $urandom_range(0, 9);
        if (term <= 5) begin
            word_q.push_back({1'b0, 8'd0});
        end else if (term <= 7) begin
            word_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else if (term == 9) begin
            // trailing characters after the stop are ignored
            word_q.push_back({1'b0, 8'd0});
            repeat ($urandom_range(1, 3)) word_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        // term 8 leaves the string open; the next first flag drops it
        if (word_q.size() == 0) begin
            word_q.push_back({1'b0, 8'd0});
        end
        word_q[0][CHAR_WIDTH] = 1'b1;
    endtask

    // raw bytes with a sparse, random first flag
    task automatic build_noise();
        repeat ($urandom_range(1, 6)) begin
            word_q.push_back({($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255))});
        end
    endtask

    initial begin
        int phase_start;
        int strings;
        int retunes;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed corners, reset radix is decimal ----
        send_text("\t9z");          // blank, digit, stop on a letter above the base
        send_char(8'hFF, 1'b1);     // no digits at all
        send_char("a", 1'b0);       // idle character, no result
        send_char("5", 1'b1);       // dropped by the restart below
        send_char(8'd0, 1'b1);      // restart on a bare NUL
        drain();
        write_radix(BASE_HEX);
        send_text("0xg");           // prefix with nothing after it
        send_text("ffffffff");      // exactly the maximum, no overflow
        send_char(8'd0, 1'b0);
        drain();
        write_radix(RADIX_MAX);
        send_text("zzzzzzz");       // seventh digit overflows
        drain();
        write_radix(RADIX_OVER);
        send_char("5", 1'b1);       // radix out of range
        drain();

        // ---- random strings under three idle profiles ----
        retunes = 0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 7;  recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_start = chars_sent;
            strings = 0;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                if (strings % RETUNE_EVERY == 0) begin
                    retune(pick_radix(retunes));
                    retunes++;
                end
                // receiver holds off while the sender keeps going, so the
                // character queue fills and the input stalls
                if (strings == 5 && ph != 1) begin
                    hold_reqs++;
                end
                if ($urandom_range(0, 99) < 85) begin
                    build_number();
                end else begin
                    build_noise();
                end
                send_words();
                strings++;
            end
        end
        drain();

        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        $display("covered: %0d characters, %0d result words (%0d overflowed), %0d radix writes",
                 chars_seen, numbers_seen, overflows_seen, radix_writes);
        $display("covered: three idle profiles, receiver hold-offs, 32-bit boundary values");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
